### hw/rtl/sacl_pkg.sv
// Shared constants, codes and controller/datapath interface types for the LRU cache model.
package sacl_pkg;

  localparam int SACL_MAX_SET_BITS = 6;
  localparam int SACL_MAX_WAYS     = 8;
  localparam int SACL_TAG_WIDTH    = 32;

  localparam int OP_W    = 2;
  localparam int ADDR_W  = 64;
  localparam int TOTAL_W = 32;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

  localparam logic [OP_W-1:0] OP_FETCH  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OP_W-1:0] OP_STORE  = 2'd2;
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  typedef struct packed {
    logic clr_wr;     // write a cleared row at the sweep pointer
    logic load_item;  // capture the request
    logic rd;         // read the set row
    logic upd;        // resolve the access and write the row back
    logic fin;        // load the result registers
  } ctrl_cmd_t;

  typedef struct packed {
    logic            clr_last;
    logic [OP_W-1:0] op;
  } ctrl_sts_t;

endpackage

### hw/rtl/sacl_ctrl.sv
// Controller state machine sequencing clear sweep, set reads and write-backs.
module sacl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          in_operation,
  input  sacl_pkg::ctrl_sts_t sts,
  output sacl_pkg::ctrl_cmd_t cmd,
  output logic                busy
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_RD    = 5'b00100,
    ST_UPD   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   pass2_r, pass2_nxt;
  logic   accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    pass2_nxt = pass2_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          pass2_nxt     = 1'b0;
          state_nxt     = (in_operation == sacl_pkg::OP_FETCH) ? ST_FIN : ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        if (sts.op == sacl_pkg::OP_MODIFY && !pass2_r) begin
          pass2_nxt = 1'b1;
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      pass2_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass2_r <= pass2_nxt;
    end
  end

endmodule

### hw/rtl/sacl_dp.sv
// Datapath: config registers, set memory, hit/victim logic, counters and result registers.
module sacl_dp #(
  parameter int MAX_SET_BITS = sacl_pkg::SACL_MAX_SET_BITS,
  parameter int MAX_WAYS     = sacl_pkg::SACL_MAX_WAYS,
  parameter int TAG_WIDTH    = sacl_pkg::SACL_TAG_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sacl_pkg::ctrl_cmd_t                  cmd,
  output sacl_pkg::ctrl_sts_t                  sts,
  input  logic                                 cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [sacl_pkg::OP_W-1:0]            in_operation,
  input  logic [sacl_pkg::ADDR_W-1:0]          in_address,
  output logic                                 out_valid,
  output logic [1:0]                           out_hits,
  output logic                                 out_misses,
  output logic                                 out_evictions,
  output logic [sacl_pkg::TOTAL_W-1:0]         out_hit_total,
  output logic [sacl_pkg::TOTAL_W-1:0]         out_miss_total,
  output logic [sacl_pkg::TOTAL_W-1:0]         out_evict_total
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_IW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_IW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AGE_W    = WAY_IW;
  localparam logic [AGE_W-1:0]  AGE_MAX  = AGE_W'(MAX_WAYS - 1);
  localparam logic [SET_IW-1:0] SET_LAST = SET_IW'(NUM_SETS - 1);
  localparam logic [3:0]        SB_MAX   = 4'(MAX_SET_BITS);
  localparam logic [4:0]        NW_MAX   = 5'(MAX_WAYS);

  // configuration
  logic [2:0] set_bits_r;
  logic [3:0] ways_r;
  logic [5:0] block_bits_r;

  // request
  logic [sacl_pkg::OP_W-1:0]   op_r;
  logic [sacl_pkg::ADDR_W-1:0] addr_r;
  logic [SET_IW-1:0]           set_r;
  logic [TAG_WIDTH-1:0]        tag_r;
  logic [SET_IW-1:0]           clr_cnt_r;

  // set memory, one row per set
  logic [MAX_WAYS-1:0]                 mem_valid [NUM_SETS];
  logic [MAX_WAYS-1:0][TAG_WIDTH-1:0]  mem_tag   [NUM_SETS];
  logic [MAX_WAYS-1:0][AGE_W-1:0]      mem_age   [NUM_SETS];
  logic [MAX_WAYS-1:0]                 rd_valid_r;
  logic [MAX_WAYS-1:0][TAG_WIDTH-1:0]  rd_tag_r;
  logic [MAX_WAYS-1:0][AGE_W-1:0]      rd_age_r;

  // counters
  logic [1:0]                   nh_r;
  logic                         nm_r, ne_r;
  logic [sacl_pkg::TOTAL_W-1:0] hit_total_r, miss_total_r, evict_total_r;
  logic                         out_valid_r;
  logic [1:0]                   out_hits_r;
  logic                         out_misses_r, out_evictions_r;
  logic [sacl_pkg::TOTAL_W-1:0] out_hit_total_r, out_miss_total_r, out_evict_total_r;

  // address split
  logic [3:0]                  sb;
  logic [6:0]                  shift;
  logic [sacl_pkg::ADDR_W-1:0] set_full, tag_full;
  logic [SET_IW-1:0]           set_mask, set_idx;
  logic [TAG_WIDTH-1:0]        tag_val;

  always_comb begin
    sb = ({1'b0, set_bits_r} > SB_MAX) ? SB_MAX : {1'b0, set_bits_r};
    shift    = 7'(block_bits_r) + 7'(sb);
    set_full = addr_r >> block_bits_r;
    tag_full = addr_r >> shift;
    for (int i = 0; i < SET_IW; i++) begin
      set_mask[i] = (4'(i) < sb);
    end
    set_idx = set_full[SET_IW-1:0] & set_mask;
    tag_val = (shift >= 7'd64) ? '0 : tag_full[TAG_WIDTH-1:0];
  end

  // access resolution over the row just read
  logic [4:0]                          nw;
  logic [MAX_WAYS-1:0]                 in_use, hit_vec, inv_vec;
  logic                                hit, any_inv, evict;
  logic [WAY_IW-1:0]                   hit_way, inv_way, lru_way, pick;
  logic [AGE_W-1:0]                    best_age, hit_age;
  logic [MAX_WAYS-1:0]                 wr_valid;
  logic [MAX_WAYS-1:0][TAG_WIDTH-1:0]  wr_tag;
  logic [MAX_WAYS-1:0][AGE_W-1:0]      wr_age;
  logic                                younger;

  always_comb begin
    if (ways_r == 4'd0) begin
      nw = 5'd1;
    end else if ({1'b0, ways_r} > NW_MAX) begin
      nw = NW_MAX;
    end else begin
      nw = {1'b0, ways_r};
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]  = (5'(w) < nw);
      hit_vec[w] = in_use[w] && rd_valid_r[w] && (rd_tag_r[w] == tag_r);
      inv_vec[w] = in_use[w] && !rd_valid_r[w];
    end
    hit     = |hit_vec;
    any_inv = |inv_vec;
    hit_way = '0;
    inv_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = WAY_IW'(w);
      if (inv_vec[w]) inv_way = WAY_IW'(w);
    end
    // oldest way, lowest index wins ties
    best_age = '0;
    lru_way  = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && rd_age_r[w] > best_age) begin
        best_age = rd_age_r[w];
        lru_way  = WAY_IW'(w);
      end
    end
    evict   = !hit && !any_inv;
    pick    = hit ? hit_way : (any_inv ? inv_way : lru_way);
    hit_age = rd_age_r[hit_way];
    for (int w = 0; w < MAX_WAYS; w++) begin
      younger     = hit ? (rd_age_r[w] < hit_age) : 1'b1;
      wr_valid[w] = rd_valid_r[w];
      wr_tag[w]   = rd_tag_r[w];
      wr_age[w]   = rd_age_r[w];
      if (WAY_IW'(w) == pick) begin
        wr_valid[w] = 1'b1;
        wr_tag[w]   = tag_r;
        wr_age[w]   = '0;
      end else if (in_use[w] && rd_valid_r[w] && younger && rd_age_r[w] < AGE_MAX) begin
        wr_age[w] = rd_age_r[w] + 1'b1;
      end
    end
  end

  // set memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem_valid[clr_cnt_r] <= '0;
      mem_tag[clr_cnt_r]   <= '0;
      mem_age[clr_cnt_r]   <= '0;
    end else if (cmd.upd) begin
      mem_valid[set_r] <= wr_valid;
      mem_tag[set_r]   <= wr_tag;
      mem_age[set_r]   <= wr_age;
    end
    if (cmd.rd) begin
      rd_valid_r <= mem_valid[set_idx];
      rd_tag_r   <= mem_tag[set_idx];
      rd_age_r   <= mem_age[set_idx];
    end
  end

  // request capture, address split and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r   <= in_operation;
      addr_r <= in_address;
    end
    if (cmd.rd) begin
      set_r <= set_idx;
      tag_r <= tag_val;
    end
    if (cmd.fin) begin
      out_hits_r        <= nh_r;
      out_misses_r      <= nm_r;
      out_evictions_r   <= ne_r;
      out_hit_total_r   <= hit_total_r;
      out_miss_total_r  <= miss_total_r;
      out_evict_total_r <= evict_total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= 3'd0;
      ways_r        <= 4'd1;
      block_bits_r  <= 6'd0;
      clr_cnt_r     <= '0;
      nh_r          <= 2'd0;
      nm_r          <= 1'b0;
      ne_r          <= 1'b0;
      hit_total_r   <= '0;
      miss_total_r  <= '0;
      evict_total_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin;
      if (cfg_we) begin
        case (cfg_index)
          sacl_pkg::CFG_SET_BITS:   set_bits_r   <= cfg_data[2:0];
          sacl_pkg::CFG_WAYS:       ways_r       <= cfg_data[3:0];
          sacl_pkg::CFG_BLOCK_BITS: block_bits_r <= cfg_data;
          default:                  ;
        endcase
      end
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.load_item) begin
        nh_r <= 2'd0;
        nm_r <= 1'b0;
        ne_r <= 1'b0;
      end
      if (cmd.upd) begin
        if (hit) begin
          nh_r <= nh_r + 2'd1;
          if (hit_total_r != sacl_pkg::TOTAL_MAX) hit_total_r <= hit_total_r + 1'b1;
        end else begin
          nm_r <= 1'b1;
          if (miss_total_r != sacl_pkg::TOTAL_MAX) miss_total_r <= miss_total_r + 1'b1;
        end
        if (evict) begin
          ne_r <= 1'b1;
          if (evict_total_r != sacl_pkg::TOTAL_MAX) evict_total_r <= evict_total_r + 1'b1;
        end
      end
    end
  end

  assign sts.clr_last = (clr_cnt_r == SET_LAST);
  assign sts.op       = op_r;

  assign out_valid       = out_valid_r;
  assign out_hits        = out_hits_r;
  assign out_misses      = out_misses_r;
  assign out_evictions   = out_evictions_r;
  assign out_hit_total   = out_hit_total_r;
  assign out_miss_total  = out_miss_total_r;
  assign out_evict_total = out_evict_total_r;

endmodule

### hw/rtl/set_assoc_cache_lru_sim_top.sv
// Top level of the set-associative LRU cache tag store model.
// A request is accepted only while busy is low and runs to completion before the next.
// A load or store costs one set-row read and one row write-back, a modify two of each,
// a fetch none; rows go through the single read port and the single write port.
// Results are strobed for one cycle on out_valid; the receiver cannot stall them.
// Reset: a clearing pass over every set row keeps busy high.
module set_assoc_cache_lru_sim_top #(
  parameter int MAX_SET_BITS = sacl_pkg::SACL_MAX_SET_BITS,
  parameter int MAX_WAYS     = sacl_pkg::SACL_MAX_WAYS,
  parameter int TAG_WIDTH    = sacl_pkg::SACL_TAG_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            start,
  output logic                            busy,
  input  logic [sacl_pkg::OP_W-1:0]       in_operation,
  input  logic [sacl_pkg::ADDR_W-1:0]     in_address,
  // result channel
  output logic                            out_valid,
  output logic [1:0]                      out_hits,
  output logic                            out_misses,
  output logic                            out_evictions,
  output logic [sacl_pkg::TOTAL_W-1:0]    out_hit_total,
  output logic [sacl_pkg::TOTAL_W-1:0]    out_miss_total,
  output logic [sacl_pkg::TOTAL_W-1:0]    out_evict_total,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data
);

  sacl_pkg::ctrl_cmd_t cmd;
  sacl_pkg::ctrl_sts_t sts;

  // Config writes land at any time, also during the clearing pass.
  assign cfg_ready = 1'b1;

  // Sequence: clear sweep after reset, then per request read row, resolve and
  // write back (twice for a modify, not at all for a fetch), then load the result registers.
  sacl_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy)
  );

  // Hold the set memory, the hit/victim logic, the saturating totals and the
  // result registers.
  sacl_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .TAG_WIDTH    (TAG_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_operation    (in_operation),
    .in_address      (in_address),
    .out_valid       (out_valid),
    .out_hits        (out_hits),
    .out_misses      (out_misses),
    .out_evictions   (out_evictions),
    .out_hit_total   (out_hit_total),
    .out_miss_total  (out_miss_total),
    .out_evict_total (out_evict_total)
  );

endmodule
